>>> sv/lvg3d_pkg.sv
package lvg3d_pkg;

	localparam int COORD_W = 4;
	localparam int LEVEL_W = 4;
	localparam int SIZE_W  = 5;
	localparam int SPAN_W  = 4;
	localparam int ERR_W   = 7;
	localparam int AXES    = 3;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	// Largest coordinate the walk uses; larger inputs saturate to it.
	localparam int COORD_MAX = 15;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] start_z;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [COORD_W-1:0] end_z;
		logic [LEVEL_W-1:0] brightness;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] voxel_x;
		logic [COORD_W-1:0] voxel_y;
		logic [COORD_W-1:0] voxel_z;
		logic [LEVEL_W-1:0] level;
		logic               in_bounds;
		logic               last;
	} voxel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic done;
	} status_t;

	function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
		logic [COORD_W-1:0] r;
		if (int'(v) > COORD_MAX) begin
			r = COORD_W'(COORD_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> sv/lvg3d_ctrl.sv
module lvg3d_ctrl
	import lvg3d_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	output logic    voxel_valid,
	input  logic    voxel_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t state_q;
	logic   voxel_valid_q;

	assign item_ready  = (state_q == ST_IDLE);
	assign voxel_valid = voxel_valid_q;

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && item_valid;
		cmd.emit = (state_q == ST_WALK) && (!voxel_valid_q || voxel_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			voxel_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				voxel_valid_q <= 1'b1;
			end else if (voxel_ready) begin
				voxel_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					// The endpoint goes out on the emit that sees no steps left.
					if (cmd.emit && status.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/lvg3d_datapath.sv
module lvg3d_datapath
	import lvg3d_pkg::*;
(
	input  logic              clk,
	input  item_t             item,
	input  logic [SIZE_W-1:0] size_x,
	input  logic [SIZE_W-1:0] size_y,
	input  logic [SIZE_W-1:0] size_z,
	input  cmd_t              cmd,
	output status_t           status,
	output voxel_t            voxel
);

	logic [COORD_W-1:0] st[AXES];
	logic [COORD_W-1:0] en[AXES];
	logic [SPAN_W-1:0]  span[AXES];
	logic               neg[AXES];
	axis_t              maj_l, a_l, b_l;
	logic [SPAN_W-1:0]  sm_l, sa_l, sb_l;

	logic [COORD_W-1:0] cursor_q[AXES];
	logic               neg_q[AXES];
	axis_t              maj_q, a_q, b_q;
	logic signed [ERR_W-1:0] sm2_q, sa2_q, sb2_q;
	logic signed [ERR_W-1:0] ea_q, eb_q;
	logic [SPAN_W-1:0]  steps_q;
	logic [LEVEL_W-1:0] level_q;
	voxel_t             voxel_q;

	logic               mova, movb;
	logic signed [ERR_W-1:0] ea_nxt, eb_nxt;
	logic               move[AXES];
	logic               inb;

	always_comb begin
		st[0] = clamp_coord(item.start_x);
		st[1] = clamp_coord(item.start_y);
		st[2] = clamp_coord(item.start_z);
		en[0] = clamp_coord(item.end_x);
		en[1] = clamp_coord(item.end_y);
		en[2] = clamp_coord(item.end_z);
		for (int i = 0; i < AXES; i++) begin
			neg[i]  = en[i] < st[i];
			span[i] = neg[i] ? (st[i] - en[i]) : (en[i] - st[i]);
		end
		// Ties go to x first, then y.
		if (span[0] >= span[1] && span[0] >= span[2]) begin
			maj_l = AXIS_X; a_l = AXIS_Y; b_l = AXIS_Z;
			sm_l  = span[0]; sa_l = span[1]; sb_l = span[2];
		end else if (span[1] >= span[2]) begin
			maj_l = AXIS_Y; a_l = AXIS_X; b_l = AXIS_Z;
			sm_l  = span[1]; sa_l = span[0]; sb_l = span[2];
		end else begin
			maj_l = AXIS_Z; a_l = AXIS_Y; b_l = AXIS_X;
			sm_l  = span[2]; sa_l = span[1]; sb_l = span[0];
		end
	end

	always_comb begin
		mova   = ea_q > 0;
		movb   = eb_q > 0;
		ea_nxt = ea_q - (mova ? sm2_q : ERR_W'(0)) + sa2_q;
		eb_nxt = eb_q - (movb ? sm2_q : ERR_W'(0)) + sb2_q;
		for (int i = 0; i < AXES; i++) begin
			move[i] = (maj_q == axis_t'(i)) || (mova && (a_q == axis_t'(i)))
				|| (movb && (b_q == axis_t'(i)));
		end
		inb = ({1'b0, cursor_q[0]} < size_x) && ({1'b0, cursor_q[1]} < size_y)
			&& ({1'b0, cursor_q[2]} < size_z);
	end

	assign status.done = (steps_q == '0);
	assign voxel       = voxel_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < AXES; i++) begin
				cursor_q[i] <= st[i];
				neg_q[i]    <= neg[i];
			end
			maj_q   <= maj_l;
			a_q     <= a_l;
			b_q     <= b_l;
			sm2_q   <= ERR_W'(sm_l) <<< 1;
			sa2_q   <= ERR_W'(sa_l) <<< 1;
			sb2_q   <= ERR_W'(sb_l) <<< 1;
			ea_q    <= (ERR_W'(sa_l) <<< 1) - ERR_W'(sm_l);
			eb_q    <= (ERR_W'(sb_l) <<< 1) - ERR_W'(sm_l);
			steps_q <= sm_l;
			level_q <= item.brightness;
		end else if (cmd.emit) begin
			voxel_q.voxel_x   <= cursor_q[0];
			voxel_q.voxel_y   <= cursor_q[1];
			voxel_q.voxel_z   <= cursor_q[2];
			voxel_q.level     <= level_q;
			voxel_q.in_bounds <= inb;
			voxel_q.last      <= status.done;
			if (!status.done) begin
				for (int i = 0; i < AXES; i++) begin
					if (move[i]) begin
						cursor_q[i] <= neg_q[i] ? (cursor_q[i] - 1'b1)
							: (cursor_q[i] + 1'b1);
					end
				end
				ea_q    <= ea_nxt;
				eb_q    <= eb_nxt;
				steps_q <= steps_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/line_voxel_generator_3d.sv
// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_ready   item_t: start, end, brightness
// voxel     out        voxel_valid / voxel_ready voxel_t: position, level, flags
// config    in         APB psel / penable        size_x, size_y, size_z at 0, 4, 8
//
// A line is loaded, then walked one voxel per cycle while the voxel output is not
// stalled, by the single stepping unit in the datapath.
// Reset clears the controller and sets every cube size to eight.
// A stalled voxel beat holds the walk; a new line is taken as soon as the
// previous endpoint sits in the output register, even if it is not yet taken.
module line_voxel_generator_3d
	import lvg3d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              voxel_valid,
	input  logic              voxel_ready,
	output voxel_t            voxel,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic              wr_en;
	cmd_t              cmd;
	status_t           status;

	// Registers are one word apart; the low address bits select nothing.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RESET;
			size_y_q <= SIZE_RESET;
			size_z_q <= SIZE_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_SIZE_X: size_x_q <= pwdata[SIZE_W-1:0];
				REG_SIZE_Y: size_y_q <= pwdata[SIZE_W-1:0];
				REG_SIZE_Z: size_z_q <= pwdata[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Reads of an unused address return zero.
	always_comb begin
		case (paddr[3:2])
			REG_SIZE_X: prdata = APB_DW'(size_x_q);
			REG_SIZE_Y: prdata = APB_DW'(size_y_q);
			REG_SIZE_Z: prdata = APB_DW'(size_z_q);
			default:    prdata = '0;
		endcase
	end

	// The controller sequences load and emit; the datapath owns the walk.
	lvg3d_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.voxel_valid (voxel_valid),
		.voxel_ready (voxel_ready),
		.status      (status),
		.cmd         (cmd)
	);

	lvg3d_datapath u_datapath (
		.clk    (clk),
		.item   (item),
		.size_x (size_x_q),
		.size_y (size_y_q),
		.size_z (size_z_q),
		.cmd    (cmd),
		.status (status),
		.voxel  (voxel)
	);

endmodule
